// ----- src/assert_macros.svh -----
// assertion macros included by the top level core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/lgs_pkg.sv -----
// package for the life grid generation step core: codes, sizes, rule constants
`default_nettype none

package lgs_pkg;

    localparam int LGS_GRID_ROWS = 64;
    localparam int LGS_GRID_COLS = 64;

    localparam int ROW_INDEX_W = 6;
    localparam int COL_INDEX_W = 6;
    localparam int REQ_TYPE_W  = 2;

    // neighbor counts of rule b3/s23
    localparam logic [3:0] NBR_BIRTH   = 4'd3;
    localparam logic [3:0] NBR_SURVIVE = 4'd2;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_SET    = 2'd0,
        REQ_TOGGLE = 2'd1,
        REQ_STEP   = 2'd2,
        REQ_READ   = 2'd3
    } req_code_t;

endpackage

`default_nettype wire

// ----- src/lgs_ram.sv -----
// generic single write port, single read port ram with registered read data
`default_nettype none

module lgs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- src/lgs_row_unit.sv -----
// shared row update unit: next generation of one row from three neighbor rows
`default_nettype none

module lgs_row_unit
    import lgs_pkg::*;
#(
    parameter int GRID_COLS = LGS_GRID_COLS
) (
    input  wire logic [GRID_COLS-1:0] row_above,
    input  wire logic [GRID_COLS-1:0] row_cur,
    input  wire logic [GRID_COLS-1:0] row_below,
    output logic      [GRID_COLS-1:0] row_next
);

    // zero padding on both sides models dead cells beyond the edges
    logic [GRID_COLS+1:0] pad_above;
    logic [GRID_COLS+1:0] pad_cur;
    logic [GRID_COLS+1:0] pad_below;

    assign pad_above = {1'b0, row_above, 1'b0};
    assign pad_cur   = {1'b0, row_cur, 1'b0};
    assign pad_below = {1'b0, row_below, 1'b0};

    for (genvar c = 0; c < GRID_COLS; c++)
    begin : g_col
        logic [3:0] nbr_count;

        assign nbr_count = 4'(pad_above[c]) + 4'(pad_above[c+1]) + 4'(pad_above[c+2])
                         + 4'(pad_cur[c])                        + 4'(pad_cur[c+2])
                         + 4'(pad_below[c]) + 4'(pad_below[c+1]) + 4'(pad_below[c+2]);

        assign row_next[c] = (nbr_count == NBR_BIRTH)
                          || ((nbr_count == NBR_SURVIVE) && row_cur[c]);
    end

endmodule

`default_nettype wire

// ----- src/life_grid_generation_step_core.sv -----
// top level of the life grid generation step core: sequencer, grid ram, row unit
// set, toggle, read: ST_OP_RD, ST_OP_WR, then ST_DONE until the output register is free
// generation step: ST_PRIME0 and ST_PRIME1, then ST_RUN and ST_DONE; ST_RUN writes rows
//   one row per cycle through the shared row unit, bounded by the single ram write port
// one transaction in flight; the next input is taken once the sequencer is back to idle,
//   even while the previous result still waits on the output register
// reset: asynchronous, active low; afterwards a clearing pass in ST_CLEAR
//   zeroes the grid, one row per cycle, with req_ready low
`default_nettype none

module life_grid_generation_step_core
    import lgs_pkg::*;
#(
    parameter int GRID_ROWS = LGS_GRID_ROWS,
    parameter int GRID_COLS = LGS_GRID_COLS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    output logic                        req_ready,
    input  wire logic [REQ_TYPE_W-1:0]  req_type,
    input  wire logic [ROW_INDEX_W-1:0] row_index,
    input  wire logic [COL_INDEX_W-1:0] col_index,
    input  wire logic                   cell_in,
    output logic                        rsp_valid,
    input  wire logic                   rsp_ready,
    output logic                        cell_out,
    output logic      [REQ_TYPE_W-1:0]  done_type
);

    `include "assert_macros.svh"

    localparam int RW = $clog2(GRID_ROWS);
    localparam int CW = $clog2(GRID_COLS);

    // one-hot sequencer states
    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,  // zeroing the grid after reset
        ST_IDLE   = 8'b0000_0010,  // waiting for a request
        ST_OP_RD  = 8'b0000_0100,  // read the addressed row
        ST_OP_WR  = 8'b0000_1000,  // modify and write back the addressed row
        ST_PRIME0 = 8'b0001_0000,  // step: fetch row 0
        ST_PRIME1 = 8'b0010_0000,  // step: load row 0, fetch row 1
        ST_RUN    = 8'b0100_0000,  // step: one row per cycle
        ST_DONE   = 8'b1000_0000   // hand result to the output register
    } state_t;

    state_t state_reg, state_next;

    logic [RW-1:0]           idx_reg, idx_next;
    logic [REQ_TYPE_W-1:0]   op_reg, op_next;
    logic [RW-1:0]           row_sel_reg, row_sel_next;
    logic [CW-1:0]           col_sel_reg, col_sel_next;
    logic                    val_reg, val_next;
    logic                    in_range_reg, in_range_next;
    logic                    cell_res_reg, cell_res_next;
    logic [GRID_COLS-1:0]    row_above_reg, row_above_next;
    logic [GRID_COLS-1:0]    row_cur_reg, row_cur_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    logic                    cell_out_reg, cell_out_next;
    logic [REQ_TYPE_W-1:0]   done_type_reg, done_type_next;

    // grid ram ports
    logic                    wr_en;
    logic [RW-1:0]           wr_addr;
    logic [GRID_COLS-1:0]    wr_data;
    logic [RW-1:0]           rd_addr;
    logic [GRID_COLS-1:0]    rd_data;

    // row unit ports
    logic [GRID_COLS-1:0]    row_below;
    logic [GRID_COLS-1:0]    row_next;

    // helpers
    logic [31:0]             row_ext;
    logic [31:0]             col_ext;
    logic                    idx_last;
    logic [RW:0]             idx_plus2;
    logic [GRID_COLS-1:0]    bit_mask;
    logic [GRID_COLS-1:0]    mod_row;
    logic                    req_fire;
    logic                    rsp_free;

    assign req_fire  = req_valid && req_ready;
    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_free  = !rsp_valid_reg || rsp_ready;

    assign row_ext   = 32'(row_index);
    assign col_ext   = 32'(col_index);
    assign idx_last  = (idx_reg == RW'(GRID_ROWS - 1));
    assign idx_plus2 = {1'b0, idx_reg} + (RW+1)'(2);

    // bottom edge: no row below the last one
    assign row_below = idx_last ? '0 : rd_data;

    assign bit_mask = {{(GRID_COLS-1){1'b0}}, 1'b1} << col_sel_reg;

    // read-modify-write of one cell
    always_comb
    begin
        unique case (op_reg)
            REQ_SET:
            begin
                mod_row = val_reg ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
            end
            REQ_TOGGLE:
            begin
                mod_row = rd_data ^ bit_mask;
            end
            default:
            begin
                mod_row = rd_data;
            end
        endcase
    end

    lgs_ram #(
        .WIDTH (GRID_COLS),
        .DEPTH (GRID_ROWS)
    ) u_grid_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lgs_row_unit #(
        .GRID_COLS (GRID_COLS)
    ) u_row_unit (
        .row_above (row_above_reg),
        .row_cur   (row_cur_reg),
        .row_below (row_below),
        .row_next  (row_next)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        op_next        = op_reg;
        row_sel_next   = row_sel_reg;
        col_sel_next   = col_sel_reg;
        val_next       = val_reg;
        in_range_next  = in_range_reg;
        cell_res_next  = cell_res_reg;
        row_above_next = row_above_reg;
        row_cur_next   = row_cur_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cell_out_next  = cell_out_reg;
        done_type_next = done_type_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = row_next;
        rd_addr        = row_sel_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_data = '0;
                if (idx_last)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + RW'(1);
                end
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    op_next       = req_type;
                    row_sel_next  = row_ext[RW-1:0];
                    col_sel_next  = col_ext[CW-1:0];
                    val_next      = cell_in;
                    in_range_next = (row_ext < 32'(GRID_ROWS))
                                 && (col_ext < 32'(GRID_COLS));
                    state_next    = (req_type == REQ_STEP) ? ST_PRIME0 : ST_OP_RD;
                end
            end
            ST_OP_RD:
            begin
                state_next = ST_OP_WR;
            end
            ST_OP_WR:
            begin
                // out-of-range addresses leave the grid alone and report dead
                wr_en         = in_range_reg
                             && ((op_reg == REQ_SET) || (op_reg == REQ_TOGGLE));
                wr_addr       = row_sel_reg;
                wr_data       = mod_row;
                cell_res_next = in_range_reg && ((mod_row & bit_mask) != '0);
                state_next    = ST_DONE;
            end
            ST_PRIME0:
            begin
                rd_addr        = '0;
                row_above_next = '0;
                idx_next       = '0;
                state_next     = ST_PRIME1;
            end
            ST_PRIME1:
            begin
                rd_addr      = RW'(1);
                row_cur_next = rd_data;
                state_next   = ST_RUN;
            end
            ST_RUN:
            begin
                // write row idx, fetch row idx+2 as the row below the next one
                wr_en          = 1'b1;
                wr_addr        = idx_reg;
                wr_data        = row_next;
                rd_addr        = idx_plus2[RW-1:0];
                row_above_next = row_cur_reg;
                row_cur_next   = row_below;
                cell_res_next  = 1'b0;
                if (idx_last)
                begin
                    idx_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + RW'(1);
                end
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    cell_out_next  = cell_res_reg;
                    done_type_next = op_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        row_sel_reg   <= row_sel_next;
        col_sel_reg   <= col_sel_next;
        val_reg       <= val_next;
        in_range_reg  <= in_range_next;
        cell_res_reg  <= cell_res_next;
        row_above_reg <= row_above_next;
        row_cur_reg   <= row_cur_next;
        cell_out_reg  <= cell_out_next;
        done_type_reg <= done_type_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign cell_out  = cell_out_reg;
    assign done_type = done_type_reg;

    // during a step the row being written is never the row being fetched
    `ASSERT_IMPL(a_run_no_collision, state_reg == ST_RUN, wr_addr != rd_addr,
        "row write collides with row fetch during a step")
    // a step result always reports a dead cell
    `ASSERT_IMPL(a_step_cell_zero, rsp_valid_reg && (done_type_reg == REQ_STEP),
        !cell_out_reg, "step result carries a live cell")
    // out-of-range set or toggle leaves the grid untouched
    `ASSERT_IMPL(a_oor_no_write, (state_reg == ST_OP_WR) && !in_range_reg, !wr_en,
        "out-of-range request wrote the grid")
    // an accepted request takes the sequencer out of idle
    `ASSERT_NEXT(a_busy_after_accept, req_fire, !req_ready,
        "sequencer ready again right after a transaction")

endmodule

`default_nettype wire

// ----- bench/tb_life_grid_generation_step_core.sv -----
// testbench for the life grid generation step core: grid mirror, request driver, result checker
`default_nettype none

// software copy of the grid that works out the expected result of every request
class life_grid_mirror;

    typedef struct {
        logic              cell_val;
        lgs_pkg::req_code_t kind;
    } life_result_t;

    bit [lgs_pkg::LGS_GRID_COLS-1:0] grid_now [lgs_pkg::LGS_GRID_ROWS];
    life_result_t awaited_results [$];
    int mismatch_count;

    function int live_neighbors(int row, int col);
        int n;
        int rr;
        int cc;
        n = 0;
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dc = -1; dc <= 1; dc++)
            begin
                rr = row + dr;
                cc = col + dc;
                if ((dr != 0 || dc != 0) && rr >= 0 && rr < lgs_pkg::LGS_GRID_ROWS
                    && cc >= 0 && cc < lgs_pkg::LGS_GRID_COLS)
                    n += grid_now[rr][cc];
            end
        end
        return n;
    endfunction

    // one generation of rule b3/s23, cells off the edges count as dead
    function void evolve_grid();
        bit [lgs_pkg::LGS_GRID_COLS-1:0] grid_next [lgs_pkg::LGS_GRID_ROWS];
        int n;
        for (int r = 0; r < lgs_pkg::LGS_GRID_ROWS; r++)
        begin
            for (int c = 0; c < lgs_pkg::LGS_GRID_COLS; c++)
            begin
                n = live_neighbors(r, c);
                grid_next[r][c] = (n == lgs_pkg::NBR_BIRTH)
                    || (n == lgs_pkg::NBR_SURVIVE && grid_now[r][c]);
            end
        end
        grid_now = grid_next;
    endfunction

    function void note_request(lgs_pkg::req_code_t kind, int row, int col, bit value);
        life_result_t res;
        res.kind = kind;
        res.cell_val = 1'b0;
        if (kind == lgs_pkg::REQ_STEP)
            evolve_grid();
        else if (row < lgs_pkg::LGS_GRID_ROWS && col < lgs_pkg::LGS_GRID_COLS)
        begin
            case (kind)
                lgs_pkg::REQ_SET:    grid_now[row][col] = value;
                lgs_pkg::REQ_TOGGLE: grid_now[row][col] = ~grid_now[row][col];
                default:             ;
            endcase
            res.cell_val = grid_now[row][col];
        end
        awaited_results.push_back(res);
    endfunction

    function void report(string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch: %s", what);
    endfunction

    function void check_result(logic cell_val, logic [lgs_pkg::REQ_TYPE_W-1:0] kind);
        life_result_t res;
        if (awaited_results.size() == 0)
        begin
            report($sformatf("result with none awaited: cell_out %b done_type %0d",
                             cell_val, kind));
            return;
        end
        res = awaited_results.pop_front();
        if (res.cell_val !== cell_val || res.kind !== kind)
            report($sformatf("expected cell_out %b done_type %s, got cell_out %b done_type %0d",
                             res.cell_val, res.kind.name(), cell_val, kind));
    endfunction

    function int pending();
        return awaited_results.size();
    endfunction

endclass

module tb_life_grid_generation_step_core;
    import lgs_pkg::*;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // request channel, known values from time zero
    logic                   req_valid = 1'b0;
    logic                   req_ready;
    logic [REQ_TYPE_W-1:0]  req_type  = REQ_READ;
    logic [ROW_INDEX_W-1:0] row_index = '0;
    logic [COL_INDEX_W-1:0] col_index = '0;
    logic                   cell_in   = 1'b0;

    // result channel
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    logic                  cell_out;
    logic [REQ_TYPE_W-1:0] done_type;

    // idle percentages of the two sides, changed per phase
    int send_idle_pct = 26;
    int recv_idle_pct = 53;
    int requests_sent = 0;

    life_grid_mirror grid_mirror;

    always #1 clk = ~clk;

    life_grid_generation_step_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_type  (req_type),
        .row_index (row_index),
        .col_index (col_index),
        .cell_in   (cell_in),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cell_out  (cell_out),
        .done_type (done_type)
    );

    // one request transaction; valid stays up from the previous transaction
    // unless an idle cycle lowers it, so valid never gets two updates in one step
    task automatic send_request(req_code_t kind, int row, int col, bit value);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type  <= kind;
        row_index <= row[ROW_INDEX_W-1:0];
        col_index <= col[COL_INDEX_W-1:0];
        cell_in   <= value;
        // values seen right after the edge are the ones the block sampled
        do
            @(posedge clk);
        while (!req_ready);
        grid_mirror.note_request(kind, row, col, value);
        requests_sent++;
    endtask

    // sender holds off until every awaited result has come back
    task automatic wait_for_drain();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (grid_mirror.pending() != 0);
    endtask

    // window corners lean toward the grid edges so edge cells see real traffic
    function automatic int pick_window_base(int span);
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return span - 4;
            default: return $urandom_range(0, span - 4);
        endcase
    endfunction

    // well-formed burst: seed a small pattern, evolve it, then probe around it
    task automatic pattern_burst();
        int base_row;
        int base_col;
        int seeds;
        int steps;
        int probes;
        base_row = pick_window_base(LGS_GRID_ROWS);
        base_col = pick_window_base(LGS_GRID_COLS);
        seeds  = $urandom_range(3, 8);
        steps  = $urandom_range(1, 3);
        probes = $urandom_range(2, 6);
        repeat (seeds)
        begin
            if ($urandom_range(0, 4) == 0)
                send_request(REQ_TOGGLE, base_row + $urandom_range(0, 3),
                             base_col + $urandom_range(0, 3), $urandom_range(0, 1));
            else
                send_request(REQ_SET, base_row + $urandom_range(0, 3),
                             base_col + $urandom_range(0, 3), $urandom_range(0, 4) != 0);
        end
        repeat (steps)
        begin
            send_request(REQ_STEP, $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 1));
            if ($urandom_range(0, 1) == 1)
                send_request(REQ_READ, base_row + $urandom_range(0, 3),
                             base_col + $urandom_range(0, 3), $urandom_range(0, 1));
        end
        repeat (probes)
            send_request(REQ_READ, base_row + $urandom_range(0, 3),
                         base_col + $urandom_range(0, 3), $urandom_range(0, 1));
    endtask

    // unstructured noise: any operation on any cell
    task automatic noise_request();
        req_code_t kind;
        kind = req_code_t'($urandom_range(0, 3));
        send_request(kind, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1));
    endtask

    task automatic random_phase(int quota);
        int pick;
        quota += requests_sent;
        while (requests_sent < quota)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                pattern_burst();
            else if (pick < 96)
                noise_request();
            else
                wait_for_drain();
        end
        wait_for_drain();
    endtask

    // result side: check at each edge with the values the block saw,
    // then pick the stall for the next cycle
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && rsp_ready)
                grid_mirror.check_result(cell_out, done_type);
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // main sequence
    initial
    begin
        grid_mirror = new;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty grid, corners, toggles, clear, blinker, edge block
        send_request(REQ_READ,   0,  0, 1'b1);
        send_request(REQ_SET,    0,  0, 1'b1);
        send_request(REQ_SET,    0, 63, 1'b1);
        send_request(REQ_SET,   63,  0, 1'b1);
        send_request(REQ_SET,   63, 63, 1'b1);
        send_request(REQ_TOGGLE, 63, 63, 1'b0);
        send_request(REQ_TOGGLE, 63, 63, 1'b1);
        send_request(REQ_SET,    0,  0, 1'b0);
        send_request(REQ_SET,   31, 40, 1'b1);
        send_request(REQ_SET,   32, 40, 1'b1);
        send_request(REQ_SET,   33, 40, 1'b1);
        send_request(REQ_SET,    0, 62, 1'b1);
        send_request(REQ_SET,    1, 62, 1'b1);
        send_request(REQ_SET,    1, 63, 1'b1);
        send_request(REQ_STEP,  63, 63, 1'b1);
        send_request(REQ_READ,  32, 39, 1'b0);
        send_request(REQ_READ,  32, 41, 1'b0);
        send_request(REQ_READ,   0, 63, 1'b0);
        send_request(REQ_READ,  63,  0, 1'b0);
        send_request(REQ_STEP,   0,  0, 1'b0);
        send_request(REQ_READ,  31, 40, 1'b0);
        send_request(REQ_READ,  63, 63, 1'b0);
        // pressure: hold off until the directed results are all back
        wait_for_drain();

        // random phases: sender idles less, then receiver idles less, then no idling
        random_phase(427);
        send_idle_pct = 53;
        recv_idle_pct = 26;
        random_phase(427);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(427);

        // a step result is the longest, allow one more of it before the verdict
        repeat (LGS_GRID_ROWS + 8) @(posedge clk);
        if (grid_mirror.mismatch_count == 0 && grid_mirror.pending() == 0)
            $display("tb_life_grid_generation_step_core: done, clean");
        else
            $display("tb_life_grid_generation_step_core: done, errors");
        $finish;
    end

    // watchdog, several times the slowest run with every request a step
    initial
    begin
        #1200000;
        $display("tb_life_grid_generation_step_core: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
